// File: rtl/core/pui_pkg.sv
// ----------------------------------------------------------------------------
// pui_pkg
// shared types and constants for the insertion-order permutation unranker
// ----------------------------------------------------------------------------
package pui_pkg;

  localparam int IndexW = 16;
  localparam int SizeW  = 4;
  localparam logic [SizeW-1:0] SizeReset = 4'd8;

  // one per-slot result request driven by the serializer (pui_emit) to the outputs
  typedef struct packed {
    logic [2:0] slot;
    logic [2:0] element_at_slot;
    logic [2:0] slot_of_element;
    logic       last;
    logic       index_error;
  } result_t;

endpackage

// File: rtl/core/pui_digits.sv
// ----------------------------------------------------------------------------
// pui_digits
// splits the index into mixed-radix digits, one radix per pipeline stage
// ----------------------------------------------------------------------------
module pui_digits import pui_pkg::*; #(
  parameter int MaxElements = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic [IndexW-1:0]            in_index,
  input  logic [SizeW-1:0]             in_size,
  output logic                         out_valid,
  output logic [MaxElements-1:0][3:0]  out_digit,
  output logic [SizeW-1:0]             out_size,
  output logic                         out_error
);

  localparam int NSt = MaxElements - 1;

  logic [NSt:0]                         v;
  logic [NSt:0][IndexW-1:0]             rem;
  logic [NSt:0][SizeW-1:0]              sz;
  logic [NSt:0][MaxElements-1:0][3:0]   dg;

  // stage i divides by radix k = MaxElements - i if k <= size, else digit 0
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v <= {v[NSt-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    rem[0] <= in_index;
    sz[0]  <= in_size;
    dg[0]  <= '0;
  end

  for (genvar i = 0; i < NSt; i++) begin : g_st
    localparam int K = MaxElements - i;
    localparam int Sh = IndexW + $clog2(K);
    localparam longint Mag = ((longint'(1) << Sh) + longint'(K) - 1) / longint'(K);
    localparam int PW = 2 * IndexW + 2;
    logic [PW-1:0]     prod;
    logic [IndexW-1:0] q;
    logic [3:0]        r;
    // quotient by reciprocal multiplication, exact over the index range
    always_comb begin
      prod = PW'(rem[i]) * PW'(Mag);
      q = IndexW'(prod >> Sh);
      r = 4'(rem[i] - q * IndexW'(K));
    end
    always_ff @(posedge clk) begin
      sz[i+1]  <= sz[i];
      dg[i+1]  <= dg[i];
      if (SizeW'(K) <= sz[i]) begin
        rem[i+1]      <= q;
        dg[i+1][K-1]  <= r;
      end else begin
        rem[i+1] <= rem[i];
      end
    end
  end

  assign out_valid = v[NSt];
  assign out_digit = dg[NSt];
  assign out_size  = sz[NSt];
  assign out_error = (rem[NSt] != '0);

endmodule

// File: rtl/core/pui_build.sv
// ----------------------------------------------------------------------------
// pui_build
// inserts one element per stage, then forms the inverse
// ----------------------------------------------------------------------------
module pui_build import pui_pkg::*; #(
  parameter int MaxElements = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic [MaxElements-1:0][3:0]  in_digit,
  input  logic [SizeW-1:0]             in_size,
  input  logic                         in_error,
  output logic                         out_valid,
  output logic [MaxElements-1:0][3:0]  out_perm,
  output logic [MaxElements-1:0][3:0]  out_inv,
  output logic [SizeW-1:0]             out_size,
  output logic                         out_error
);

  localparam int NSt = MaxElements - 1;

  logic [NSt:0]                         v;
  logic [NSt:0][MaxElements-1:0][3:0]   pm;
  logic [NSt:0][MaxElements-1:0][3:0]   dg;
  logic [NSt:0][SizeW-1:0]              sz;
  logic [NSt:0]                         err;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v <= {v[NSt-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    pm[0]  <= '0;
    dg[0]  <= in_digit;
    sz[0]  <= in_size;
    err[0] <= in_error;
  end

  // stage i inserts element k = i + 1 when k < size
  for (genvar i = 0; i < NSt; i++) begin : g_ins
    localparam int K = i + 1;
    logic [MaxElements-1:0][3:0] nxt;
    always_comb begin
      for (int j = 0; j < MaxElements; j++) begin
        if (32'(dg[i][K]) > 32'(j)) nxt[j] = pm[i][j];
        else if (32'(dg[i][K]) == 32'(j)) nxt[j] = 4'(K);
        else if (j > 0) nxt[j] = pm[i][(j > 0) ? j - 1 : 0];
        else nxt[j] = pm[i][j];
      end
    end
    always_ff @(posedge clk) begin
      dg[i+1]  <= dg[i];
      sz[i+1]  <= sz[i];
      err[i+1] <= err[i];
      pm[i+1]  <= (SizeW'(K) < sz[i]) ? nxt : pm[i];
    end
  end

  logic                        ov;
  logic [MaxElements-1:0][3:0] opm, oinv;
  logic [SizeW-1:0]            osz;
  logic                        oerr;

  always_ff @(posedge clk) begin
    if (rst) ov <= 1'b0;
    else ov <= v[NSt];
  end

  always_ff @(posedge clk) begin
    opm  <= pm[NSt];
    osz  <= sz[NSt];
    oerr <= err[NSt];
    for (int e = 0; e < MaxElements; e++) begin
      oinv[e] <= '0;
      for (int j = 0; j < MaxElements; j++) begin
        if (pm[NSt][j] == 4'(e) && SizeW'(j) < sz[NSt]) oinv[e] <= 4'(j);
      end
    end
  end

  assign out_valid = ov;
  assign out_perm  = opm;
  assign out_inv   = oinv;
  assign out_size  = osz;
  assign out_error = oerr;

endmodule

// File: rtl/core/pui_emit.sv
// ----------------------------------------------------------------------------
// pui_emit
// serializes one permutation into per-slot result requests
// ----------------------------------------------------------------------------
module pui_emit import pui_pkg::*; #(
  parameter int MaxElements = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic [MaxElements-1:0][3:0]  in_perm,
  input  logic [MaxElements-1:0][3:0]  in_inv,
  input  logic [SizeW-1:0]             in_size,
  input  logic                         in_error,
  output logic                         out_valid,
  output result_t                      out_res
);

  logic                        act;
  logic [MaxElements-1:0][3:0] pm, iv;
  logic [SizeW-1:0]            sz;
  logic                        err;
  logic [3:0]                  j;
  logic                        fin;

  assign fin = err || (SizeW'(j) + 1'b1 >= sz);

  always_ff @(posedge clk) begin
    if (rst) begin
      act <= 1'b0;
    end else if (in_valid) begin
      act <= 1'b1;
    end else if (act && fin) begin
      act <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      pm  <= in_perm;
      iv  <= in_inv;
      sz  <= in_size;
      err <= in_error;
      j   <= '0;
    end else if (act) begin
      j <= j + 1'b1;
    end
  end

  assign out_valid = act;
  always_comb begin
    out_res.slot            = 3'(j);
    out_res.element_at_slot = err ? 3'd0 : 3'(pm[j[2:0]]);
    out_res.slot_of_element = err ? 3'd0 : 3'(iv[j[2:0]]);
    out_res.last            = fin;
    out_res.index_error     = err;
  end

  assert property (@(posedge clk) disable iff (rst) act && err |-> fin);
  assert property (@(posedge clk) disable iff (rst) in_valid |=> act && j == 0);
  assert property (@(posedge clk) disable iff (rst) act && !fin && !in_valid |=> act);

endmodule

// File: rtl/core/permutation_unrank_insertion.sv
// ----------------------------------------------------------------------------
// permutation_unrank_insertion
// returns the permutation at a given insertion-order index and its inverse
// ----------------------------------------------------------------------------
// usage:
//   write perm_size on cfg_valid/cfg_ready (always ready) while idle
//   raise start with perm_index; the request is taken when busy is low
//   results come one per cycle on strobe: slot, element_at_slot,
//   slot_of_element, last and index_error; the receiver cannot stall
//   an index of K! or more gives one result with index_error set
// accept to first result: the digit input register and stages, the insertion
//   input register and stages, the inverse register, the serializer register
// an index error gives a single result but busy is held as for K results
// busy stays high while the output serializer would be overrun
// reset: perm_size returns to 8 and the pipeline empties
// ----------------------------------------------------------------------------
module permutation_unrank_insertion import pui_pkg::*; #(
  parameter int MAX_ELEMENTS = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [IndexW-1:0] perm_index,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [SizeW-1:0]  cfg_data,
  output logic              strobe,
  output logic [2:0]        slot,
  output logic [2:0]        element_at_slot,
  output logic [2:0]        slot_of_element,
  output logic              last,
  output logic              index_error
);

  localparam int CntW = $clog2(MAX_ELEMENTS + 1);

  logic [SizeW-1:0] perm_size, ksz;
  logic [CntW-1:0]  credit;
  logic             acc;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) perm_size <= SizeReset;
    else if (cfg_valid && cfg_ready) perm_size <= cfg_data;
  end

  assign ksz = (perm_size == '0) ? SizeW'(1) :
               (32'(perm_size) > MAX_ELEMENTS) ? SizeW'(MAX_ELEMENTS) : perm_size;

  // space the requests so the serializer never overruns
  assign busy = (credit != '0);
  assign acc  = start && !busy;
  always_ff @(posedge clk) begin
    if (rst) credit <= '0;
    else if (acc) credit <= CntW'(ksz - 1'b1);
    else if (credit != '0) credit <= credit - 1'b1;
  end

  logic                           dv, bv;
  logic [MAX_ELEMENTS-1:0][3:0]   dg, pm, iv;
  logic [SizeW-1:0]               dsz, bsz;
  logic                           derr, berr;
  result_t                        res;

  pui_digits #(.MaxElements(MAX_ELEMENTS)) u_dig (
    .clk, .rst, .in_valid(acc), .in_index(perm_index), .in_size(ksz),
    .out_valid(dv), .out_digit(dg), .out_size(dsz), .out_error(derr)
  );

  pui_build #(.MaxElements(MAX_ELEMENTS)) u_bld (
    .clk, .rst, .in_valid(dv), .in_digit(dg), .in_size(dsz), .in_error(derr),
    .out_valid(bv), .out_perm(pm), .out_inv(iv), .out_size(bsz), .out_error(berr)
  );

  pui_emit #(.MaxElements(MAX_ELEMENTS)) u_emit (
    .clk, .rst, .in_valid(bv), .in_perm(pm), .in_inv(iv), .in_size(bsz),
    .in_error(berr), .out_valid(strobe), .out_res(res)
  );

  assign slot            = res.slot;
  assign element_at_slot = res.element_at_slot;
  assign slot_of_element = res.slot_of_element;
  assign last            = res.last;
  assign index_error     = res.index_error;

  assert property (@(posedge clk) disable iff (rst) acc |=> busy || ksz == 1);
  assert property (@(posedge clk) disable iff (rst) strobe && index_error |-> last);
  assert property (@(posedge clk) disable iff (rst) strobe && index_error |-> slot == 0);

endmodule
